// ===== src/key_matrix_scan_debounce_macros.svh =====
// ---------------------------------------------------------------------------
// Key matrix scanner assertion macros
// Shared concurrent check forms used by the scanner top level.
// ---------------------------------------------------------------------------
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_MACROS_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define KMSD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmsd: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define KMSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmsd: next-cycle check failed");

`endif

// ===== src/kmsd_pkg.sv =====
// ---------------------------------------------------------------------------
// Key matrix scanner package
// Field widths, defaults, register codes and shared types.
// ---------------------------------------------------------------------------
package kmsd_pkg;

  // Field widths
  localparam int ROW_W      = 2;
  localparam int COL_W      = 2;
  localparam int LEVEL_BITS = 4;
  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 8;

  // Defaults for the top-level parameters
  localparam int ROWS_DEFAULT        = 4;
  localparam int COLS_DEFAULT        = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd10;

  typedef enum logic [0:0] {
    REG_DEBOUNCE = 1'b0,
    REG_NONE     = 1'b1
  } kmsd_reg_t;

  // One row sample that changed at least one key
  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic [LEVEL_BITS-1:0] event_mask;
    logic [LEVEL_BITS-1:0] press_mask;
  } kmsd_evt_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } kmsd_qstat_t;

endpackage

// ===== src/kmsd_if.sv =====
// ---------------------------------------------------------------------------
// Key matrix scanner channels
// Valid/ready channels for row samples and key events.
// ---------------------------------------------------------------------------
interface kmsd_in_if;
  import kmsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ROW_W-1:0]      row_index;
  logic [LEVEL_BITS-1:0] column_levels;
  logic [TIME_W-1:0]     now_ms;

  modport source (output valid, output row_index, output column_levels, output now_ms,
                  input ready);
  modport sink   (input valid, input row_index, input column_levels, input now_ms,
                  output ready);
endinterface

interface kmsd_out_if;
  import kmsd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] key_row;
  logic [COL_W-1:0] key_column;
  logic             is_press;
  logic             last_event;

  modport source (output valid, output key_row, output key_column, output is_press,
                  output last_event, input ready);
  modport sink   (input valid, input key_row, input key_column, input is_press,
                  input last_event, output ready);
endinterface

// ===== src/kmsd_front.sv =====
// ---------------------------------------------------------------------------
// Key matrix scanner front end
// Accepts row samples, updates key state and classifies press/release words.
// ---------------------------------------------------------------------------
module kmsd_front #(
  parameter int ROWS = kmsd_pkg::ROWS_DEFAULT,
  parameter int COLS = kmsd_pkg::COLS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [kmsd_pkg::DEBOUNCE_W-1:0] debounce_ms,
  kmsd_in_if.sink                        samples,
  input  kmsd_pkg::kmsd_qstat_t          qstat,
  output logic                           push,
  output kmsd_pkg::kmsd_evt_t            evt
);
  import kmsd_pkg::*;

  // Only rows and columns reachable through the sample fields hold state
  localparam int SCAN_ROWS = (ROWS < (1 << ROW_W)) ? ROWS : (1 << ROW_W);
  localparam int SCAN_COLS = (COLS < LEVEL_BITS) ? COLS : LEVEL_BITS;
  localparam int RIDX_W    = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;

  logic [SCAN_COLS-1:0] key_down   [SCAN_ROWS];
  logic [TIME_W-1:0]    press_time [SCAN_ROWS][SCAN_COLS];

  logic                  accept;
  logic                  row_ok;
  logic                  wr_en;
  logic [RIDX_W-1:0]     ridx;
  logic [SCAN_COLS-1:0]  down_row;
  logic [SCAN_COLS-1:0]  down_next;
  logic [LEVEL_BITS-1:0] event_mask;
  logic [LEVEL_BITS-1:0] press_mask;
  logic [TIME_W-1:0]     elapsed [SCAN_COLS];

  // Take a sample whenever the queue has room
  assign samples.ready = !qstat.full;
  assign accept        = samples.valid && samples.ready;
  assign row_ok        = (32'(samples.row_index) < 32'(ROWS));
  assign ridx          = samples.row_index[RIDX_W-1:0];
  assign down_row      = key_down[ridx];
  assign wr_en         = accept && row_ok;

  // Classify each column of the addressed row in parallel
  always_comb begin
    event_mask = '0;
    press_mask = '0;
    down_next  = down_row;
    for (int j = 0; j < SCAN_COLS; j++) begin
      elapsed[j] = samples.now_ms - press_time[ridx][j];
      if (samples.column_levels[j] && !down_row[j]) begin
        press_mask[j] = 1'b1;
        event_mask[j] = 1'b1;
        down_next[j]  = 1'b1;
      end else if (!samples.column_levels[j] && down_row[j] &&
                   (elapsed[j] > TIME_W'(debounce_ms))) begin
        event_mask[j] = 1'b1;
        down_next[j]  = 1'b0;
      end
    end
  end

  // Hand changed rows to the queue, drop quiet ones
  assign push           = wr_en && (event_mask != '0);
  assign evt.row        = samples.row_index;
  assign evt.event_mask = event_mask;
  assign evt.press_mask = press_mask;

  // Update the pressed flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < SCAN_ROWS; r++) begin
        key_down[r] <= '0;
      end
    end else if (wr_en) begin
      key_down[ridx] <= down_next;
    end
  end

  // Record press times
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int j = 0; j < SCAN_COLS; j++) begin
        if (press_mask[j]) begin
          press_time[ridx][j] <= samples.now_ms;
        end
      end
    end
  end

endmodule

// ===== src/kmsd_queue.sv =====
// ---------------------------------------------------------------------------
// Key matrix scanner event queue
// Short first-in first-out buffer of changed rows between front and back.
// ---------------------------------------------------------------------------
module kmsd_queue #(
  parameter int DEPTH = kmsd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  kmsd_pkg::kmsd_evt_t   wr_data,
  input  logic                  pop,
  output kmsd_pkg::kmsd_evt_t   head,
  output kmsd_pkg::kmsd_qstat_t qstat
);
  import kmsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kmsd_evt_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  // Advance pointers with wrap at the queue depth
  assign wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // Hold pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== src/kmsd_back.sv =====
// ---------------------------------------------------------------------------
// Key matrix scanner back end
// Splits each changed row into key event words, lowest column first.
// ---------------------------------------------------------------------------
module kmsd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  kmsd_pkg::kmsd_evt_t   head,
  input  kmsd_pkg::kmsd_qstat_t qstat,
  output logic                  pop,
  kmsd_out_if.source            events
);
  import kmsd_pkg::*;

  logic [LEVEL_BITS-1:0] sent;
  logic [LEVEL_BITS-1:0] sent_next;
  logic [LEVEL_BITS-1:0] pending;
  logic [LEVEL_BITS-1:0] lowest;
  logic [COL_W-1:0]      col;
  logic                  is_last;
  logic                  load;

  logic                  valid;
  logic [ROW_W-1:0]      key_row;
  logic [COL_W-1:0]      key_column;
  logic                  is_press;
  logic                  last_event;

  // Pick the lowest column still to be sent
  assign pending = head.event_mask & ~sent;
  assign lowest  = pending & (~pending + 1'b1);
  assign is_last = ((pending & ~lowest) == '0);

  always_comb begin
    col = '0;
    for (int j = LEVEL_BITS - 1; j >= 0; j--) begin
      if (pending[j]) begin
        col = COL_W'(j);
      end
    end
  end

  // Load the output register when it is free or being drained
  assign load = !qstat.empty && (!valid || events.ready);
  assign pop  = load && is_last;

  always_comb begin
    sent_next = sent;
    if (pop) begin
      sent_next = '0;
    end else if (load) begin
      sent_next = sent | lowest;
    end
  end

  // Track columns already sent for the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      sent  <= '0;
      valid <= 1'b0;
    end else begin
      sent <= sent_next;
      if (load) begin
        valid <= 1'b1;
      end else if (events.ready) begin
        valid <= 1'b0;
      end
    end
  end

  // Hold the event word until taken
  always_ff @(posedge clk) begin
    if (load) begin
      key_row    <= head.row;
      key_column <= col;
      is_press   <= |(head.press_mask & lowest);
      last_event <= is_last;
    end
  end

  assign events.valid      = valid;
  assign events.key_row    = key_row;
  assign events.key_column = key_column;
  assign events.is_press   = is_press;
  assign events.last_event = last_event;

endmodule

// ===== src/key_matrix_scan_debounce.sv =====
// ---------------------------------------------------------------------------
// Key matrix scanner with release debounce
// Turns sampled matrix rows into ordered key press and release events.
// ---------------------------------------------------------------------------
// Usage:
//   samples : one word per driven row (row_index, column_levels, now_ms).
//   events  : one word per key that changed, ascending column order, with
//             last_event set on the final word of a sample. Quiet samples
//             and rows beyond ROWS produce no words.
//   APB     : register 0 at byte address 0 holds debounce_ms (reset 10).
//             Write only while no sample is in flight.
// Timing:
//   A sample is taken whenever the event queue has room, so samples may
//   arrive every cycle. Its first event word passes through the queue and
//   is then loaded into the output register; its events then leave one per
//   cycle while events.ready is high, one word per changed key (1 to 4).
//   Sustained throughput is set by the single-word output register.
// Reset:
//   Every key goes idle, the queue empties and debounce_ms returns to 10.
// Stall:
//   While events.ready is low the output word holds; samples are still taken
//   until the QUEUE_DEPTH-entry queue fills, then samples.ready drops.
// ---------------------------------------------------------------------------
`include "key_matrix_scan_debounce_macros.svh"

module key_matrix_scan_debounce #(
  parameter int ROWS        = kmsd_pkg::ROWS_DEFAULT,
  parameter int COLS        = kmsd_pkg::COLS_DEFAULT,
  parameter int QUEUE_DEPTH = kmsd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  kmsd_in_if.sink                         samples,
  kmsd_out_if.source                      events,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kmsd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [kmsd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [kmsd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import kmsd_pkg::*;

  logic [DEBOUNCE_W-1:0] debounce_ms;
  kmsd_reg_t             reg_sel;
  logic                  cfg_write;
  logic                  push;
  logic                  pop;
  kmsd_evt_t             evt;
  kmsd_evt_t             head;
  kmsd_qstat_t           qstat;

  // Decode the register port
  assign pready    = 1'b1;
  assign reg_sel   = (paddr == '0) ? REG_DEBOUNCE : REG_NONE;
  assign cfg_write = psel && penable && pwrite && pready && (reg_sel == REG_DEBOUNCE);

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE: prdata = APB_DATA_W'(debounce_ms);
      default:      prdata = '0;
    endcase
  end

  // Hold the debounce setting
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      debounce_ms <= pwdata[DEBOUNCE_W-1:0];
    end
  end

  kmsd_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .debounce_ms (debounce_ms),
    .samples     (samples),
    .qstat       (qstat),
    .push        (push),
    .evt         (evt)
  );

  kmsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (evt),
    .pop     (pop),
    .head    (head),
    .qstat   (qstat)
  );

  kmsd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .events (events)
  );

  // Checks
  `KMSD_ASSERT_NEXT(a_cfg_write, clk, rst, cfg_write, debounce_ms == $past(pwdata[DEBOUNCE_W-1:0]))
  `KMSD_ASSERT_SAME(a_push_on_accept, clk, rst, push, samples.valid && samples.ready)
  `KMSD_ASSERT_SAME(a_queue_flags, clk, rst, qstat.full, !qstat.empty)
  `KMSD_ASSERT_SAME(a_more_pending, clk, rst, events.valid && !events.last_event, !qstat.empty)

endmodule

// ===== bench/tb_key_matrix_scan_debounce.sv =====
// ---------------------------------------------------------------------------
// Key matrix scanner testbench
// Feeds row samples with bursty valid and a stalling event sink, predicts
// the press and release words of every accepted sample, and compares each
// event word in order. The debounce register is rewritten between phases.
// ---------------------------------------------------------------------------
module tb_key_matrix_scan_debounce;
  import kmsd_pkg::*;

  localparam int NKEYS       = ROWS_DEFAULT * COLS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 10;

  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic [LEVEL_BITS-1:0] levels;
    logic [TIME_W-1:0]     now;
  } row_sample_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             press;
    logic             last;
  } key_event_t;

  logic clk = 1'b0;
  logic rst;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  kmsd_in_if  sample_ch ();
  kmsd_out_if event_ch ();

  key_matrix_scan_debounce DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .events  (event_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Predictor state: one flag and one press tick per key
  logic                  key_held   [NKEYS];
  logic [TIME_W-1:0]     press_tick [NKEYS];
  logic [DEBOUNCE_W-1:0] debounce_setting;

  row_sample_t row_samples_todo [$];
  key_event_t  key_events_due   [$];

  // Stimulus bookkeeping
  logic [TIME_W-1:0]     tick;
  logic [LEVEL_BITS-1:0] finger_mask [ROWS_DEFAULT];

  int errors;
  int cycles;
  int samples_taken;
  int presses_seen;
  int releases_seen;
  int settings_used;

  logic        sample_taken;
  int          burst_left;
  int          gap_left;
  row_sample_t next_sample;
  logic [7:0]  ready_pattern;
  int          pattern_age;

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR @%0d: %s", cycles, msg);
    end
  endtask

  // Work out the event words one accepted row sample causes
  function automatic void predict_key_changes(row_sample_t s);
    int unsigned       k;
    logic [TIME_W-1:0] held_for;
    key_event_t        ev;
    key_event_t        batch [$];
    if (s.row < ROWS_DEFAULT) begin
      for (int c = 0; c < COLS_DEFAULT && c < LEVEL_BITS; c++) begin
        k        = s.row * COLS_DEFAULT + c;
        held_for = s.now - press_tick[k];
        ev.row   = s.row;
        ev.col   = COL_W'(c);
        ev.last  = 1'b0;
        if (s.levels[c] && !key_held[k]) begin
          key_held[k]   = 1'b1;
          press_tick[k] = s.now;
          ev.press      = 1'b1;
          batch.push_back(ev);
        end else if (!s.levels[c] && key_held[k] && held_for > TIME_W'(debounce_setting)) begin
          key_held[k] = 1'b0;
          ev.press    = 1'b0;
          batch.push_back(ev);
        end
      end
    end
    foreach (batch[i]) begin
      ev      = batch[i];
      ev.last = (i == batch.size() - 1);
      key_events_due.push_back(ev);
    end
  endfunction

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d event words outstanding",
               cycles, key_events_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sample driver: bursts of words with random gaps
  always @(negedge clk) begin
    if (!rst && (!sample_ch.valid || sample_taken)) begin
      if (gap_left != 0 || row_samples_todo.size() == 0) begin
        sample_ch.valid <= 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end
      end else begin
        next_sample = row_samples_todo.pop_front();
        sample_ch.valid         <= 1'b1;
        sample_ch.row_index     <= next_sample.row;
        sample_ch.column_levels <= next_sample.levels;
        sample_ch.now_ms        <= next_sample.now;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Event sink: rotate a stall pattern, replacing it whenever pattern_age wraps
  always @(negedge clk) begin
    if (!rst) begin
      if (pattern_age == 31) begin
        ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        pattern_age   <= 0;
      end else begin
        ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
        pattern_age   <= pattern_age + 1;
      end
      event_ch.ready <= ready_pattern[0];
    end
  end

  // Monitor: predict on accepted samples, check accepted event words
  always @(posedge clk) begin
    key_event_t act;
    key_event_t exp_ev;
    if (rst) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_ch.valid && sample_ch.ready;
      if (sample_ch.valid && sample_ch.ready) begin
        predict_key_changes({sample_ch.row_index, sample_ch.column_levels, sample_ch.now_ms});
        samples_taken++;
      end
      if (event_ch.valid && event_ch.ready) begin
        act = {event_ch.key_row, event_ch.key_column, event_ch.is_press, event_ch.last_event};
        if (key_events_due.size() == 0) begin
          flag_error($sformatf("unexpected word row %0d col %0d press %0d last %0d",
                               act.row, act.col, act.press, act.last));
        end else begin
          exp_ev = key_events_due.pop_front();
          if (act.row !== exp_ev.row || act.col !== exp_ev.col ||
              act.press !== exp_ev.press || act.last !== exp_ev.last) begin
            flag_error($sformatf(
              "word mismatch: exp row %0d col %0d press %0d last %0d, got %0d %0d %0d %0d",
              exp_ev.row, exp_ev.col, exp_ev.press, exp_ev.last,
              act.row, act.col, act.press, act.last));
          end
          if (act.press === 1'b1) presses_seen++;
          else releases_seen++;
        end
      end
    end
  end

  // One APB transfer: setup then access, finish on pready
  task automatic apb_xfer(input logic wr, input kmsd_reg_t r,
                          input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = APB_ADDR_W'(r) << 2;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Write a register, mirror it, then read the debounce value back
  task automatic write_register(kmsd_reg_t r, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    apb_xfer(1'b1, r, value, rd);
    if (r == REG_DEBOUNCE) begin
      debounce_setting = value[DEBOUNCE_W-1:0];
      settings_used++;
    end
    apb_xfer(1'b0, REG_DEBOUNCE, '0, rd);
    if (rd[DEBOUNCE_W-1:0] !== debounce_setting) begin
      flag_error($sformatf("debounce readback exp %0d got %0d",
                           debounce_setting, rd[DEBOUNCE_W-1:0]));
    end
  endtask

  task automatic add_sample(logic [ROW_W-1:0] row, logic [LEVEL_BITS-1:0] levels,
                            logic [TIME_W-1:0] now);
    row_samples_todo.push_back({row, levels, now});
  endtask

  // Hold until every word has drained, then let the block settle
  task automatic wait_idle();
    while (row_samples_todo.size() != 0 || sample_ch.valid || key_events_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly full scans of all rows with drifting fingers; the rest is noise
  task automatic add_scan_traffic(int n);
    int added;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 4) == 0) begin
        add_sample(ROW_W'($urandom_range(0, 3)), LEVEL_BITS'($urandom_range(0, 15)),
                   ($urandom_range(0, 1) == 0) ? tick : TIME_W'($urandom));
        added++;
      end else begin
        for (int r = 0; r < ROWS_DEFAULT; r++) begin
          if ($urandom_range(0, 2) == 0) begin
            finger_mask[r] = finger_mask[r] ^ LEVEL_BITS'($urandom);
          end
          add_sample(ROW_W'(r), finger_mask[r], tick);
        end
        added += ROWS_DEFAULT;
        if ($urandom_range(0, 9) == 0) begin
          tick = $urandom;
        end else begin
          tick = tick + $urandom_range(0, int'(debounce_setting) + 4);
        end
      end
    end
  endtask

  initial begin
    logic [APB_DATA_W-1:0] rand_word;
    rst                     = 1'b1;
    sample_ch.valid         = 1'b0;
    sample_ch.row_index     = '0;
    sample_ch.column_levels = '0;
    sample_ch.now_ms        = '0;
    event_ch.ready          = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    errors                  = 0;
    cycles                  = 0;
    samples_taken           = 0;
    presses_seen            = 0;
    releases_seen           = 0;
    settings_used           = 1;
    burst_left              = 0;
    gap_left                = 0;
    ready_pattern           = 8'hFF;
    pattern_age             = 0;
    tick                    = 32'd1000;
    debounce_setting        = DEBOUNCE_RESET;
    for (int k = 0; k < NKEYS; k++) begin
      key_held[k]   = 1'b0;
      press_tick[k] = '0;
    end
    for (int r = 0; r < ROWS_DEFAULT; r++) finger_mask[r] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset debounce: quiet, full press, repress, release at and past the window
    add_sample(2'd0, 4'h0, 32'd0);
    add_sample(2'd0, 4'hF, 32'd0);
    add_sample(2'd0, 4'hF, 32'd5);
    add_sample(2'd0, 4'h0, 32'd10);
    add_sample(2'd0, 4'h0, 32'd11);
    // Press just before the tick wraps, release just after it
    add_sample(2'd3, 4'b1010, 32'hFFFF_FFF0);
    add_sample(2'd3, 4'b0000, 32'h0000_0005);
    // Tick moving backwards reads as a long hold
    add_sample(2'd2, 4'b0101, 32'd100);
    add_sample(2'd2, 4'b0000, 32'd50);
    // Release and press in one sample, ascending column order
    add_sample(2'd1, 4'b0001, 32'd200);
    add_sample(2'd1, 4'b0010, 32'd300);
    add_sample(2'd1, 4'b0000, 32'd400);
    add_sample(2'd3, 4'hF, 32'hFFFF_FFFF);
    add_sample(2'd3, 4'h0, 32'h0000_0000);
    add_sample(2'd2, 4'b1000, 32'hAAAA_5555);
    add_sample(2'd2, 4'b0000, 32'h5555_AAAA);
    add_scan_traffic(16);
    wait_idle();

    // Zero debounce: a release in the press tick is held, one tick later it goes
    write_register(REG_DEBOUNCE, 32'd0);
    add_sample(2'd1, 4'h0, 32'h8000_0000);
    add_sample(2'd1, 4'b1000, 32'h8000_0001);
    add_sample(2'd1, 4'b0000, 32'h8000_0001);
    add_sample(2'd1, 4'b0000, 32'h8000_0002);
    add_scan_traffic(20);
    wait_idle();

    // Unknown register leaves debounce alone; then the widest window
    write_register(REG_NONE, 32'd99);
    write_register(REG_DEBOUNCE, 32'd255);
    add_sample(2'd0, 4'h0, 32'h4000_0000);
    add_sample(2'd0, 4'b0100, 32'h4000_0001);
    add_sample(2'd0, 4'b0000, 32'h4000_0100);
    add_sample(2'd0, 4'b0000, 32'h4000_0101);
    tick = 32'h4000_0200;
    add_scan_traffic(20);
    wait_idle();

    rand_word = $urandom;
    write_register(REG_DEBOUNCE, rand_word);
    add_scan_traffic(20);
    wait_idle();

    write_register(REG_DEBOUNCE, 32'd1);
    add_scan_traffic(20);
    wait_idle();

    if (key_events_due.size() != 0) begin
      flag_error($sformatf("%0d event words never arrived", key_events_due.size()));
    end
    $display("Checked %0d row samples under %0d debounce settings", samples_taken,
             settings_used);
    $display("Event words matched: %0d presses, %0d releases, %0d errors", presses_seen,
             releases_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== key_matrix_scan_debounce.f =====
+incdir+src
src/kmsd_pkg.sv
src/kmsd_if.sv
src/kmsd_front.sv
src/kmsd_queue.sv
src/kmsd_back.sv
src/key_matrix_scan_debounce.sv
bench/tb_key_matrix_scan_debounce.sv
